[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds across reset
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/srdc_pkg.sv]
`default_nettype none

package srdc_pkg;

   localparam int ELEMENT_COUNT_DEF = 1024;
   localparam int VALUE_COUNT_DEF   = 1024;

   localparam int CMD_W  = 1;
   localparam int POS_W  = 10;
   localparam int VAL_W  = 10;
   localparam int RNG_W  = 10;
   localparam int TAG_W  = 16;
   localparam int DIST_W = 11;

   localparam logic CMD_LOAD = 1'b0;

   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] S_CLR  = 4'd0;
   localparam logic [PC_W-1:0] S_IDLE = 4'd1;
   localparam logic [PC_W-1:0] S_DISP = 4'd2;
   localparam logic [PC_W-1:0] S_CHKB = 4'd3;
   localparam logic [PC_W-1:0] S_CHKE = 4'd4;
   localparam logic [PC_W-1:0] S_SEED = 4'd5;
   localparam logic [PC_W-1:0] S_MOVE = 4'd6;
   localparam logic [PC_W-1:0] S_ECRD = 4'd7;
   localparam logic [PC_W-1:0] S_ECWR = 4'd8;
   localparam logic [PC_W-1:0] S_RESP = 4'd9;
   localparam logic [PC_W-1:0] S_LD0  = 4'd10;
   localparam logic [PC_W-1:0] S_LORD = 4'd11;
   localparam logic [PC_W-1:0] S_LOWR = 4'd12;
   localparam logic [PC_W-1:0] S_LIRD = 4'd13;
   localparam logic [PC_W-1:0] S_LIWR = 4'd14;
   localparam logic [PC_W-1:0] S_LDW  = 4'd15;

   localparam int COND_W = 4;

   localparam logic [COND_W-1:0] C_NONE     = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
   localparam logic [COND_W-1:0] C_CLR_DONE = 4'd2;
   localparam logic [COND_W-1:0] C_REQ      = 4'd3;
   localparam logic [COND_W-1:0] C_LOAD     = 4'd4;
   localparam logic [COND_W-1:0] C_BAD      = 4'd5;
   localparam logic [COND_W-1:0] C_FILLED   = 4'd6;
   localparam logic [COND_W-1:0] C_SETTLED  = 4'd7;
   localparam logic [COND_W-1:0] C_RSP_FREE = 4'd8;
   localparam logic [COND_W-1:0] C_NO_COUNT = 4'd9;

   typedef struct packed {
      logic              ready;
      logic              clear;
      logic              seed;
      logic              pick;
      logic              elem_rd_pos;
      logic              cnt_rd;
      logic              cnt_src_new;
      logic              cnt_wr;
      logic              dir_set;
      logic              dir_in;
      logic              store_wr;
      logic              rsp_load;
      logic              hold;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   typedef struct packed {
      logic clr_done;
      logic req_valid;
      logic is_load;
      logic bad;
      logic filled;
      logic settled;
      logic rsp_free;
      logic no_count;
   } flags_type;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '0;
      unique case (pc)
         S_CLR: begin
            w.clear = 1'b1; w.cond = C_CLR_DONE; w.target = S_IDLE; w.hold = 1'b1;
         end
         S_IDLE: begin
            w.ready = 1'b1; w.cond = C_REQ; w.target = S_DISP; w.hold = 1'b1;
         end
         S_DISP: begin
            w.cond = C_LOAD; w.target = S_LD0;
         end
         S_CHKB: begin
            w.cond = C_BAD; w.target = S_RESP;
         end
         S_CHKE: begin
            w.cond = C_FILLED; w.target = S_MOVE;
         end
         S_SEED: begin
            w.seed = 1'b1; w.dir_set = 1'b1; w.dir_in = 1'b1;
            w.cond = C_ALWAYS; w.target = S_ECRD;
         end
         S_MOVE: begin
            w.pick = 1'b1; w.cond = C_SETTLED; w.target = S_RESP;
         end
         S_ECRD: begin
            w.cnt_rd = 1'b1; w.cond = C_NONE;
         end
         S_ECWR: begin
            w.cnt_wr = 1'b1; w.cond = C_ALWAYS; w.target = S_MOVE;
         end
         S_RESP: begin
            w.rsp_load = 1'b1; w.cond = C_RSP_FREE; w.target = S_IDLE; w.hold = 1'b1;
         end
         S_LD0: begin
            w.elem_rd_pos = 1'b1; w.dir_set = 1'b1; w.dir_in = 1'b0;
            w.cond = C_NO_COUNT; w.target = S_LDW;
         end
         S_LORD: begin
            w.cnt_rd = 1'b1; w.cond = C_NONE;
         end
         S_LOWR: begin
            w.cnt_wr = 1'b1; w.cond = C_NONE;
         end
         S_LIRD: begin
            w.cnt_rd = 1'b1; w.cnt_src_new = 1'b1; w.dir_set = 1'b1; w.dir_in = 1'b1;
            w.cond = C_NONE;
         end
         S_LIWR: begin
            w.cnt_wr = 1'b1; w.cond = C_NONE;
         end
         S_LDW: begin
            w.store_wr = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
         end
         default: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/core/srdc_ifs.sv]
`default_nettype none

interface srdc_req_if;
   logic                       valid;
   logic                       ready;
   logic [srdc_pkg::CMD_W-1:0] command;
   logic [srdc_pkg::POS_W-1:0] position;
   logic [srdc_pkg::VAL_W-1:0] element_value;
   logic [srdc_pkg::RNG_W-1:0] range_low;
   logic [srdc_pkg::RNG_W-1:0] range_high;
   logic [srdc_pkg::TAG_W-1:0] query_tag;

   modport source (output valid, command, position, element_value, range_low, range_high,
                   query_tag, input ready);
   modport sink   (input valid, command, position, element_value, range_low, range_high,
                   query_tag, output ready);
endinterface

interface srdc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [srdc_pkg::DIST_W-1:0] distinct_values;
   logic                        bad_range;
   logic [srdc_pkg::TAG_W-1:0]  answer_tag;

   modport source (output valid, distinct_values, bad_range, answer_tag, input ready);
   modport sink   (input valid, distinct_values, bad_range, answer_tag, output ready);
endinterface

`default_nettype wire

[rtl/core/sliding_range_distinct_count_top.sv]
// Distinct-value counter over a range of a stored element array.
// req_bus carries one word per command: a load (command 0) writes
// element_value at position; a query (command 1) asks for the number of
// distinct values in range_low..range_high and returns one word on rsp_bus
// carrying that count, bad_range and the caller's tag. Loads return nothing.
// A microcoded sequencer moves the window one element at a time; each
// element added or removed takes an element read, a count read and a
// count write-back through single-port memories. The first query after
// reset fills the window from empty. A load inside the window also moves
// the counts of the old and new value; a load outside it only stores.
// One word is in work at a time; req_bus.ready is high only while idle,
// from the cycle an answer appears or a load ends.
// After reset the count memory is cleared entry by entry, during which
// req_bus.ready stays low; the window starts empty.
// A stalled answer is held in the output register; the next command is
// still accepted and is held back only when its own answer is due.
`default_nettype none

module sliding_range_distinct_count_top #(
   parameter int ELEMENT_COUNT = srdc_pkg::ELEMENT_COUNT_DEF,
   parameter int VALUE_COUNT   = srdc_pkg::VALUE_COUNT_DEF
) (
   input  wire         clock,
   input  wire         reset,
   srdc_req_if.sink    req_bus,
   srdc_rsp_if.source  rsp_bus
);

   srdc_pkg::uword_type uw;
   srdc_pkg::flags_type flags;

   srdc_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uw    (uw)
   );

   srdc_dpath #(
      .ELEMENT_COUNT (ELEMENT_COUNT),
      .VALUE_COUNT   (VALUE_COUNT)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .uw    (uw),
      .flags (flags)
   );

endmodule

`default_nettype wire

[rtl/core/srdc_useq.sv]
`default_nettype none

module srdc_useq (
   input  wire                        clock,
   input  wire                        reset,
   input  wire srdc_pkg::flags_type   flags,
   output srdc_pkg::uword_type        uw
);

   logic [srdc_pkg::PC_W-1:0] pc_ff;
   logic [srdc_pkg::PC_W-1:0] pc_in;
   logic                      cond_true;

   assign uw = srdc_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (uw.cond)
         srdc_pkg::C_NONE:     cond_true = 1'b0;
         srdc_pkg::C_ALWAYS:   cond_true = 1'b1;
         srdc_pkg::C_CLR_DONE: cond_true = flags.clr_done;
         srdc_pkg::C_REQ:      cond_true = flags.req_valid;
         srdc_pkg::C_LOAD:     cond_true = flags.is_load;
         srdc_pkg::C_BAD:      cond_true = flags.bad;
         srdc_pkg::C_FILLED:   cond_true = flags.filled;
         srdc_pkg::C_SETTLED:  cond_true = flags.settled;
         srdc_pkg::C_RSP_FREE: cond_true = flags.rsp_free;
         srdc_pkg::C_NO_COUNT: cond_true = flags.no_count;
         default:              cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         pc_in = uw.target;
      end else if (uw.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= srdc_pkg::S_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/srdc_dpath.sv]
`default_nettype none

module srdc_dpath #(
   parameter int ELEMENT_COUNT = srdc_pkg::ELEMENT_COUNT_DEF,
   parameter int VALUE_COUNT   = srdc_pkg::VALUE_COUNT_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   srdc_req_if.sink                   req,
   srdc_rsp_if.source                 rsp,
   input  wire srdc_pkg::uword_type   uw,
   output srdc_pkg::flags_type        flags
);

   localparam int IDX_W  = $clog2(ELEMENT_COUNT);
   localparam int VW     = $clog2(VALUE_COUNT);
   localparam int CNT_W  = $clog2(ELEMENT_COUNT + 1);
   localparam int DIST_W = srdc_pkg::DIST_W;

   logic [VW-1:0]    elem_mem [ELEMENT_COUNT];
   logic [CNT_W-1:0] cnt_mem  [VALUE_COUNT];

   logic                          accept;
   logic [31:0]                   pos_w, val_w, rl_w, rh_w;

   logic                          cmd_ff, cmd_in;
   logic                          pos_ok_ff, pos_ok_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [VW-1:0]                 val_ff, val_in;
   logic [IDX_W-1:0]              rl_ff, rl_in, rh_ff, rh_in;
   logic [srdc_pkg::TAG_W-1:0]    tag_ff, tag_in;

   logic [IDX_W-1:0]              wl_ff, wl_in, wh_ff, wh_in;
   logic                          empty_ff, empty_in;
   logic                          dir_in_ff, dir_in_in;
   logic [CNT_W-1:0]              total_ff, total_in;
   logic [VW-1:0]                 clr_ff, clr_in;

   logic [VW-1:0]                 elem_q_ff;
   logic [CNT_W-1:0]              cnt_q_ff;
   logic [VW-1:0]                 cnt_addr_ff, cnt_addr_in;

   logic [IDX_W-1:0]              pick_idx, wl_pick, wh_pick;
   logic                          pick_dir_in;
   logic                          elem_rd;
   logic [IDX_W-1:0]              elem_addr;
   logic                          cnt_we;
   logic [CNT_W-1:0]              cnt_new;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]             rsp_dist_ff, rsp_dist_in;
   logic                          rsp_bad_ff, rsp_bad_in;
   logic [srdc_pkg::TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                          rsp_free;
   logic [DIST_W+CNT_W-1:0]       dist_wide;

   assign req.ready = uw.ready;
   assign accept    = uw.ready & req.valid;

   assign pos_w = 32'(req.position);
   assign val_w = 32'(req.element_value);
   assign rl_w  = 32'(req.range_low);
   assign rh_w  = 32'(req.range_high);

   // latch the word, saturating range bounds and values; an out-of-range position is only flagged in pos_ok
   always_comb begin
      cmd_in    = cmd_ff;
      pos_ok_in = pos_ok_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      rl_in     = rl_ff;
      rh_in     = rh_ff;
      tag_in    = tag_ff;
      if (accept) begin
         cmd_in    = req.command;
         pos_ok_in = pos_w < 32'(ELEMENT_COUNT);
         pos_in    = pos_w[IDX_W-1:0];
         val_in    = (val_w >= 32'(VALUE_COUNT)) ? VW'(VALUE_COUNT - 1) : val_w[VW-1:0];
         rl_in     = (rl_w >= 32'(ELEMENT_COUNT)) ? IDX_W'(ELEMENT_COUNT - 1)
                                                  : rl_w[IDX_W-1:0];
         rh_in     = (rh_w >= 32'(ELEMENT_COUNT)) ? IDX_W'(ELEMENT_COUNT - 1)
                                                  : rh_w[IDX_W-1:0];
         tag_in    = req.query_tag;
      end
   end

   // next window move: grow low, grow high, shrink low, shrink high
   always_comb begin
      pick_idx    = wl_ff;
      wl_pick     = wl_ff;
      wh_pick     = wh_ff;
      pick_dir_in = 1'b1;
      if (wl_ff > rl_ff) begin
         wl_pick  = wl_ff - 1'b1;
         pick_idx = wl_ff - 1'b1;
      end else if (wh_ff < rh_ff) begin
         wh_pick  = wh_ff + 1'b1;
         pick_idx = wh_ff + 1'b1;
      end else if (wl_ff < rl_ff) begin
         pick_idx    = wl_ff;
         wl_pick     = wl_ff + 1'b1;
         pick_dir_in = 1'b0;
      end else if (wh_ff > rh_ff) begin
         pick_idx    = wh_ff;
         wh_pick     = wh_ff - 1'b1;
         pick_dir_in = 1'b0;
      end
   end

   assign elem_rd   = uw.seed | uw.pick | uw.elem_rd_pos;
   assign elem_addr = uw.seed ? rl_ff : (uw.pick ? pick_idx : pos_ff);

   assign cnt_addr_in = uw.cnt_src_new ? val_ff : elem_q_ff;

   always_comb begin
      cnt_we   = 1'b0;
      cnt_new  = cnt_q_ff;
      total_in = total_ff;
      if (uw.cnt_wr) begin
         if (dir_in_ff) begin
            cnt_we  = 1'b1;
            cnt_new = cnt_q_ff + 1'b1;
            if (cnt_q_ff == '0) begin
               total_in = total_ff + 1'b1;
            end
         end else if (cnt_q_ff != '0) begin
            cnt_we  = 1'b1;
            cnt_new = cnt_q_ff - 1'b1;
            if (cnt_q_ff == CNT_W'(1)) begin
               total_in = total_ff - 1'b1;
            end
         end
      end
   end

   always_comb begin
      wl_in     = wl_ff;
      wh_in     = wh_ff;
      empty_in  = empty_ff;
      dir_in_in = dir_in_ff;
      clr_in    = clr_ff;
      if (uw.seed) begin
         wl_in    = rl_ff;
         wh_in    = rl_ff;
         empty_in = 1'b0;
      end else if (uw.pick) begin
         wl_in = wl_pick;
         wh_in = wh_pick;
      end
      if (uw.pick) begin
         dir_in_in = pick_dir_in;
      end else if (uw.dir_set) begin
         dir_in_in = uw.dir_in;
      end
      if (uw.clear) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   assign rsp_free  = ~rsp_valid_ff | rsp.ready;
   assign dist_wide = {{DIST_W{1'b0}}, total_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_tag_in   = rsp_tag_ff;
      if (uw.rsp_load && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_bad_in   = flags.bad;
         rsp_dist_in  = flags.bad ? '0 : dist_wide[DIST_W-1:0];
         rsp_tag_in   = tag_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      flags.clr_done  = clr_ff == VW'(VALUE_COUNT - 1);
      flags.req_valid = req.valid;
      flags.is_load   = cmd_ff == srdc_pkg::CMD_LOAD;
      flags.bad       = rl_ff > rh_ff;
      flags.filled    = ~empty_ff;
      flags.settled   = (wl_ff == rl_ff) && (wh_ff == rh_ff);
      flags.rsp_free  = rsp_free;
      flags.no_count  = ~pos_ok_ff | empty_ff | (pos_ff < wl_ff) | (pos_ff > wh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff        <= '0;
         wh_ff        <= '0;
         empty_ff     <= 1'b1;
         total_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wl_ff        <= wl_in;
         wh_ff        <= wh_in;
         empty_ff     <= empty_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pos_ok_ff   <= pos_ok_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      rl_ff       <= rl_in;
      rh_ff       <= rh_in;
      tag_ff      <= tag_in;
      dir_in_ff   <= dir_in_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_tag_ff  <= rsp_tag_in;
   end

   // element store
   always_ff @(posedge clock) begin
      if (elem_rd) begin
         elem_q_ff <= elem_mem[elem_addr];
      end
      if (uw.store_wr && pos_ok_ff) begin
         elem_mem[pos_ff] <= val_ff;
      end
   end

   // per-value counts
   always_ff @(posedge clock) begin
      if (uw.cnt_rd) begin
         cnt_addr_ff <= cnt_addr_in;
         cnt_q_ff    <= cnt_mem[cnt_addr_in];
      end
      if (uw.clear) begin
         cnt_mem[clr_ff] <= '0;
      end else if (cnt_we) begin
         cnt_mem[cnt_addr_ff] <= cnt_new;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.distinct_values = rsp_dist_ff;
   assign rsp.bad_range       = rsp_bad_ff;
   assign rsp.answer_tag      = rsp_tag_ff;

endmodule

`default_nettype wire

[rtl/core/srdc_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module srdc_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire [srdc_pkg::DIST_W-1:0] rsp_distinct,
   input wire                        rsp_bad,
   input wire [srdc_pkg::TAG_W-1:0]  rsp_tag
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag) && $stable(rsp_distinct) && $stable(rsp_bad))

   `ASSERT_CLK(a_bad_zero, clock, reset, rsp_valid && rsp_bad |-> rsp_distinct == '0)

   `ASSERT_CLK(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)

   `ASSERT_CLK_NR(a_reset_quiet, clock, $past(reset) |-> !req_ready && !rsp_valid)

endmodule

bind sliding_range_distinct_count_top srdc_checker u_srdc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_distinct (rsp_bus.distinct_values),
   .rsp_bad      (rsp_bus.bad_range),
   .rsp_tag      (rsp_bus.answer_tag)
);

`default_nettype wire

[sim/sliding_range_distinct_count_top_test.sv]
`timescale 1ns / 1ps

module sliding_range_distinct_count_top_test;

   localparam logic CMD_LOAD     = srdc_pkg::CMD_LOAD;
   localparam logic CMD_QUERY    = ~CMD_LOAD;
   localparam int   POS_W        = srdc_pkg::POS_W;
   localparam int   VAL_W        = srdc_pkg::VAL_W;
   localparam int   RNG_W        = srdc_pkg::RNG_W;
   localparam int   TAG_W        = srdc_pkg::TAG_W;
   localparam int   DIST_W       = srdc_pkg::DIST_W;
   localparam int   N_ELEM       = srdc_pkg::ELEMENT_COUNT_DEF;
   localparam int   N_VAL        = srdc_pkg::VALUE_COUNT_DEF;
   localparam int   REPORT_LIMIT = 10;

   typedef struct packed {
      logic [DIST_W-1:0] distinct_values;
      logic              bad_range;
      logic [TAG_W-1:0]  answer_tag;
   } range_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   srdc_req_if req_bus ();
   srdc_rsp_if rsp_bus ();

   sliding_range_distinct_count_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow of the array, the window and its value counts
   logic [VAL_W-1:0] elem_mem [N_ELEM];
   int unsigned      val_tally [N_VAL];
   int unsigned      distinct_now;
   int               win_lo;
   int               win_hi;
   bit               win_void;

   range_answer_type awaited_answers [$];
   int unsigned      error_count;
   bit               idle_on;
   int               hold_asked;
   int               hold_left;
   int               stall_left;

   function automatic void count_value_in(input int v);
      if (val_tally[v] == 0)
         distinct_now++;
      val_tally[v]++;
   endfunction

   function automatic void count_value_out(input int v);
      if (val_tally[v] == 0)
         return;
      val_tally[v]--;
      if (val_tally[v] == 0)
         distinct_now--;
   endfunction

   function automatic int fit_index(input int i);
      if (i < 0)
         return 0;
      if (i > N_ELEM - 1)
         return N_ELEM - 1;
      return i;
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch: %s", msg);
   endfunction

   // update the shadow for one accepted word; queries queue their answer
   function automatic void track_word(input logic cmd, input logic [POS_W-1:0] pos,
                                      input logic [VAL_W-1:0] val,
                                      input logic [RNG_W-1:0] lo, input logic [RNG_W-1:0] hi,
                                      input logic [TAG_W-1:0] tag);
      range_answer_type ans;
      int i;
      if (cmd == CMD_LOAD) begin
         if (!win_void && pos >= win_lo && pos <= win_hi) begin
            count_value_out(elem_mem[pos]);
            count_value_in(val);
         end
         elem_mem[pos] = val;
         return;
      end
      ans.answer_tag = tag;
      if (lo > hi) begin
         ans.distinct_values = '0;
         ans.bad_range = 1'b1;
      end else begin
         if (win_void) begin
            for (i = lo; i <= hi; i++)
               count_value_in(elem_mem[i]);
            win_lo = lo;
            win_hi = hi;
            win_void = 1'b0;
         end else begin
            while (win_lo > lo) begin
               win_lo--;
               count_value_in(elem_mem[win_lo]);
            end
            while (win_hi < hi) begin
               win_hi++;
               count_value_in(elem_mem[win_hi]);
            end
            while (win_lo < lo) begin
               count_value_out(elem_mem[win_lo]);
               win_lo++;
            end
            while (win_hi > hi) begin
               count_value_out(elem_mem[win_hi]);
               win_hi--;
            end
         end
         ans.distinct_values = DIST_W'(distinct_now);
         ans.bad_range = 1'b0;
      end
      awaited_answers = {awaited_answers, ans};
   endfunction

   task automatic send_word(input logic cmd, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val,
                            input logic [RNG_W-1:0] lo, input logic [RNG_W-1:0] hi,
                            input logic [TAG_W-1:0] tag);
      int gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.position      <= pos;
      req_bus.element_value <= val;
      req_bus.range_low     <= lo;
      req_bus.range_high    <= hi;
      req_bus.query_tag     <= tag;
      do @(posedge clock); while (!req_bus.ready);
      track_word(cmd, pos, val, lo, hi, tag);
   endtask

   task automatic load_element(input int pos, input int val);
      send_word(CMD_LOAD, POS_W'(pos), VAL_W'(val), RNG_W'($urandom), RNG_W'($urandom),
                TAG_W'($urandom));
   endtask

   task automatic ask_range(input int lo, input int hi, input int tag);
      send_word(CMD_QUERY, POS_W'($urandom), VAL_W'($urandom), RNG_W'(lo), RNG_W'(hi),
                TAG_W'(tag));
   endtask

   // mostly small window moves and loads near the window, some far jumps and bad ranges
   task automatic random_word();
      int pick;
      int lo;
      int hi;
      int d;
      int t;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 9) < 7)
            lo = fit_index(win_lo - 8 + $urandom_range(0, win_hi - win_lo + 16));
         else
            lo = $urandom_range(0, N_ELEM - 1);
         hi = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, N_VAL - 1);
         load_element(lo, hi);
      end else if (pick < 50) begin
         lo = $urandom_range(1, N_ELEM - 1);
         hi = $urandom_range(0, lo - 1);
         ask_range(lo, hi, $urandom);
      end else begin
         t = $urandom_range(0, 99);
         if (t < 4) begin
            lo = $urandom_range(0, N_ELEM - 1);
            hi = $urandom_range(lo, N_ELEM - 1);
         end else begin
            d = $urandom_range(0, 24);
            lo = fit_index(win_lo + d - 12);
            d = $urandom_range(0, 24);
            hi = fit_index(win_hi + d - 12);
            if (t < 14)
               hi = fit_index(lo + $urandom_range(0, 3));
            if (lo > hi) begin
               d = lo;
               lo = hi;
               hi = d;
            end
         end
         ask_range(lo, hi, $urandom);
      end
   endtask

   // first query fills an empty window; bad ranges; loads in and out of the window
   task automatic test_empty_window_start();
      load_element(0, 0);
      load_element(1, N_VAL - 1);
      load_element(2, 'h2AA);
      load_element(3, 'h155);
      load_element(4, 0);
      load_element(5, N_VAL - 1);
      load_element(6, 7);
      load_element(7, 7);
      ask_range(2, 5, 0);
      ask_range(5, 2, 'hFFFF);
      ask_range(1, 0, 'h5A5A);
      load_element(3, 0);
      load_element(6, 1);
      ask_range(2, 5, 'hA5A5);
      ask_range(0, 7, 1);
      ask_range(4, 4, 2);
      load_element(4, N_VAL - 1);
      ask_range(4, 4, 3);
      ask_range(7, 7, 4);
      ask_range(0, 0, 5);
   endtask

   // every element distinct, then the full span, the index extremes and bad ranges
   task automatic test_full_array();
      int p;
      for (p = 0; p < N_ELEM; p++)
         load_element(p, p);
      ask_range(0, N_ELEM - 1, 0);
      ask_range(N_ELEM - 1, N_ELEM - 1, 'hFFFF);
      ask_range(0, 0, 'h8000);
      ask_range(N_ELEM - 1, 0, 'h7FFF);
      ask_range(N_ELEM / 2, N_ELEM / 2 - 1, 'h0001);
      ask_range(0, N_ELEM - 1, 'h1234);
   endtask

   task automatic test_random_mix(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 50 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         random_word();
      end
   endtask

   // answer path held off while words keep coming
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_asked = 400;
      test_random_mix(1);
      repeat (39) random_word();
   endtask

   task automatic test_no_idle_tail();
      int n;
      idle_on = 1'b0;
      for (n = 0; n < 60; n++)
         random_word();
   endtask

   always @(posedge clock) begin
      if (hold_asked > 0) begin
         hold_left = hold_asked;
         hold_asked = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_answers
      range_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_answers.size() == 0) begin
            flag_error($sformatf("answer with no query waiting: distinct %0d bad %0b tag %h",
                                 rsp_bus.distinct_values, rsp_bus.bad_range,
                                 rsp_bus.answer_tag));
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_bus.distinct_values !== want.distinct_values)
               flag_error($sformatf("tag %h distinct_values exp %0d got %0d", want.answer_tag,
                                    want.distinct_values, rsp_bus.distinct_values));
            if (rsp_bus.bad_range !== want.bad_range)
               flag_error($sformatf("tag %h bad_range exp %0b got %0b", want.answer_tag,
                                    want.bad_range, rsp_bus.bad_range));
            if (rsp_bus.answer_tag !== want.answer_tag)
               flag_error($sformatf("answer_tag exp %h got %h", want.answer_tag,
                                    rsp_bus.answer_tag));
         end
      end
   end

   initial begin
      int i;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_LOAD;
      req_bus.position      = '0;
      req_bus.element_value = '0;
      req_bus.range_low     = '0;
      req_bus.range_high    = '0;
      req_bus.query_tag     = '0;
      rsp_bus.ready         = 1'b0;
      idle_on      = 1'b1;
      hold_asked   = 0;
      hold_left    = 0;
      stall_left   = 0;
      error_count  = 0;
      distinct_now = 0;
      win_lo       = 0;
      win_hi       = 0;
      win_void     = 1'b1;
      for (i = 0; i < N_ELEM; i++)
         elem_mem[i] = '0;
      for (i = 0; i < N_VAL; i++)
         val_tally[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_window_start();
      test_full_array();
      test_random_mix(700);
      test_output_backpressure();
      test_no_idle_tail();
      req_bus.valid <= 1'b0;
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && awaited_answers.size() == 0)
         $display("sliding_range_distinct_count_top verification clean");
      else
         $display("sliding_range_distinct_count_top verification failed");
      $finish;
   end

   initial begin
      #(24_000_000);
      $display("sliding_range_distinct_count_top verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/srdc_pkg.sv
rtl/core/srdc_ifs.sv
rtl/core/srdc_useq.sv
rtl/core/srdc_dpath.sv
rtl/core/sliding_range_distinct_count_top.sv
rtl/core/srdc_checker.sv
sim/sliding_range_distinct_count_top_test.sv
